// File: rtl/speck128_256_ctr_cipher_assert.svh
// Assertion macros for the Speck128/256 CTR cipher.
`ifndef SPECK128_256_CTR_CIPHER_ASSERT_SVH
`define SPECK128_256_CTR_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("speck ctr: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("speck ctr: next-cycle check failed");
`else
`define SCC_ASSERT_SAME(label, ante, cons)
`define SCC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/speck_ctr_pkg.sv
// Shared types, register codes and round functions for the Speck CTR cipher.
`timescale 1ns / 1ps
`default_nettype none

package speck_ctr_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;

    localparam int ROT_RIGHT = 8;
    localparam int ROT_LEFT  = 3;

    typedef logic [3:0][63:0] key_set_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } word_pair_t;

    // top -> engine control
    typedef struct packed {
        logic start;
        logic expand;
        logic take;
    } eng_req_t;

    // engine -> top status
    typedef struct packed {
        logic idle;
        logic ks_valid;
    } eng_stat_t;

    function automatic logic [63:0] ror8(input logic [63:0] v);
        ror8 = {v[ROT_RIGHT-1:0], v[63:ROT_RIGHT]};
    endfunction

    function automatic logic [63:0] rol3(input logic [63:0] v);
        rol3 = {v[63-ROT_LEFT:0], v[63:64-ROT_LEFT]};
    endfunction

    function automatic word_pair_t speck_round(input word_pair_t p, input logic [63:0] k);
        word_pair_t r;
        r.hi = (ror8(p.hi) + p.lo) ^ k;
        r.lo = rol3(p.lo) ^ r.hi;
        speck_round = r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/speck128_256_ctr_cipher.sv
// Top level of the Speck128/256 counter-mode cipher.
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four key
//    words (index 0..3) and the nonce (4 low, 5 high); other indexes are dropped.
//    cfg_ready is always high. Write only while the block is idle.
//  - in channel (in_valid/in_stall) carries one 128-bit block per transfer.
//    message_start = 1 expands the round keys alongside this block and reloads
//    the counter from the nonce for it.
//  - out channel (out_valid/out_stall) returns data XOR keystream.
// Flow: a transfer lands in an input buffer; the engine then launches it from
// its idle state, runs ROUND_COUNT rounds (one round per cycle, round keys read
// from a one-port-read memory) and hands the keystream off from its done state
// to the output register, where out_valid rises.
// The key schedule runs in step with the rounds, so a message start costs nothing.
// Throughput is set by the single round unit and its iteration over the rounds.
// A next block is taken while the current one is in flight; a finished result
// waits in the output register while the engine holds the following one.
// Reset clears valid flags, key, nonce and counter; round keys are unknown until the
// first message start. A stalled receiver backs up through the engine to in_stall.
`timescale 1ns / 1ps
`default_nettype none

module speck128_256_ctr_cipher #(
    parameter int ROUND_COUNT = 34
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [speck_ctr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                        cfg_data,
    // input blocks
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [63:0]                        data_low,
    input  wire logic [63:0]                        data_high,
    input  wire logic                               message_start,
    // results
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [63:0]                             result_low,
    output logic [63:0]                             result_high
);

    import speck_ctr_pkg::*;

    // configuration registers
    key_set_t    key_reg;
    logic [63:0] nonce_low_reg;
    logic [63:0] nonce_high_reg;

    // 128-bit counter
    logic [63:0] counter_low_reg;
    logic [63:0] counter_high_reg;
    logic [63:0] blk_lo;
    logic [63:0] blk_hi;
    logic [63:0] counter_low_next;
    logic [63:0] counter_high_next;

    // input buffer and in-flight data
    logic        inbuf_valid_reg;
    logic [63:0] inbuf_low_reg;
    logic [63:0] inbuf_high_reg;
    logic        inbuf_ms_reg;
    logic [63:0] work_low_reg;
    logic [63:0] work_high_reg;

    // output register
    logic        out_valid_reg;
    logic [63:0] out_low_reg;
    logic [63:0] out_high_reg;

    eng_req_t    eng_req;
    eng_stat_t   eng_stat;
    logic [63:0] ks_hi;
    logic [63:0] ks_lo;

    logic        in_xfer;
    logic        ks_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg        <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_WORD_0: key_reg[0]     <= cfg_data;
                CFG_KEY_WORD_1: key_reg[1]     <= cfg_data;
                CFG_KEY_WORD_2: key_reg[2]     <= cfg_data;
                CFG_KEY_WORD_3: key_reg[3]     <= cfg_data;
                CFG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                CFG_NONCE_HIGH: nonce_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // input side: single-entry buffer, free again once the engine launches it
    assign in_stall = inbuf_valid_reg;
    assign in_xfer  = in_valid && !in_stall;

    assign eng_req.start  = eng_stat.idle && inbuf_valid_reg;
    assign eng_req.expand = inbuf_ms_reg;
    assign eng_req.take   = ks_take;

    // counter value used by this block, and its successor
    assign blk_lo            = inbuf_ms_reg ? nonce_low_reg  : counter_low_reg;
    assign blk_hi            = inbuf_ms_reg ? nonce_high_reg : counter_high_reg;
    assign counter_low_next  = blk_lo + 64'd1;
    assign counter_high_next = blk_hi + {63'd0, (blk_lo == '1)};

    // output side: result moves out when the register is empty or draining
    assign ks_take = eng_stat.ks_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inbuf_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            counter_low_reg  <= '0;
            counter_high_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                inbuf_valid_reg <= 1'b1;
            end
            else if (eng_req.start)
            begin
                inbuf_valid_reg <= 1'b0;
            end

            if (eng_req.start)
            begin
                counter_low_reg  <= counter_low_next;
                counter_high_reg <= counter_high_next;
            end

            if (ks_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            inbuf_low_reg  <= data_low;
            inbuf_high_reg <= data_high;
            inbuf_ms_reg   <= message_start;
        end
        if (eng_req.start)
        begin
            work_low_reg  <= inbuf_low_reg;
            work_high_reg <= inbuf_high_reg;
        end
        if (ks_take)
        begin
            out_low_reg  <= work_low_reg ^ ks_lo;
            out_high_reg <= work_high_reg ^ ks_hi;
        end
    end

    speck_ctr_engine #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (eng_req),
        .keys   (key_reg),
        .blk_hi (blk_hi),
        .blk_lo (blk_lo),
        .stat   (eng_stat),
        .ks_hi  (ks_hi),
        .ks_lo  (ks_lo)
    );

    assign out_valid   = out_valid_reg;
    assign result_low  = out_low_reg;
    assign result_high = out_high_reg;

`include "speck128_256_ctr_cipher_assert.svh"

    // launch only from an idle engine, and the engine leaves idle right after
    `SCC_ASSERT_SAME(a_start_idle, eng_req.start, eng_stat.idle)
    `SCC_ASSERT_NEXT(a_start_busy, eng_req.start, !eng_stat.idle)
    // a finished keystream is held while the output register is blocked
    `SCC_ASSERT_NEXT(a_ks_hold, eng_stat.ks_valid && out_valid_reg && out_stall, eng_stat.ks_valid)
    // counter steps by one on a block that continues a message
    `SCC_ASSERT_NEXT(a_ctr_step, eng_req.start && !inbuf_ms_reg, counter_low_reg == $past(counter_low_reg) + 64'd1)

endmodule

`default_nettype wire

// File: rtl/speck_ctr_rk_mem.sv
// Round-key memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module speck_ctr_rk_mem #(
    parameter int DEPTH = 34,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [63:0]   wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic [63:0]        rd_data
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/speck_ctr_engine.sv
// Round engine: one Speck round per cycle, key schedule run alongside on expand.
`timescale 1ns / 1ps
`default_nettype none

module speck_ctr_engine #(
    parameter int ROUND_COUNT = 34
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire speck_ctr_pkg::eng_req_t req,
    input  wire speck_ctr_pkg::key_set_t keys,
    input  wire logic [63:0]            blk_hi,
    input  wire logic [63:0]            blk_lo,
    output speck_ctr_pkg::eng_stat_t    stat,
    output logic [63:0]                 ks_hi,
    output logic [63:0]                 ks_lo
);

    import speck_ctr_pkg::*;

    localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [RW-1:0] LAST = RW'(ROUND_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_DONE
    } state_t;

    state_t          state_reg;
    logic [RW-1:0]   round_reg;
    logic            expand_reg;
    word_pair_t      xy_reg;
    logic [63:0]     rk_reg;
    logic [63:0]     lane0_reg;
    logic [63:0]     lane1_reg;
    logic [63:0]     lane2_reg;

    logic [63:0]     rd_data;
    logic [RW-1:0]   rd_addr;
    logic            wr_en;
    logic [63:0]     key;
    word_pair_t      xy_next;
    logic [63:0]     lane_next;
    logic [63:0]     rk_next;

    // live key while expanding, stored key otherwise
    assign key       = expand_reg ? rk_reg : rd_data;
    assign xy_next   = speck_round(xy_reg, key);
    assign lane_next = (rk_reg + ror8(lane0_reg)) ^ 64'(round_reg);
    assign rk_next   = rol3(rk_reg) ^ lane_next;

    // prefetch next round's key; address 0 parked for the next item
    assign rd_addr = (state_reg == S_ROUND && round_reg != LAST) ?
                     RW'(round_reg + 1'b1) : '0;
    assign wr_en   = (state_reg == S_ROUND) && expand_reg;

    speck_ctr_rk_mem #(
        .DEPTH (ROUND_COUNT),
        .AW    (RW)
    ) u_rk_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (round_reg),
        .wr_data (rk_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            round_reg  <= '0;
            expand_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg  <= S_ROUND;
                        round_reg  <= '0;
                        expand_reg <= req.expand;
                    end
                end
                S_ROUND:
                begin
                    if (round_reg == LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        round_reg <= RW'(round_reg + 1'b1);
                    end
                end
                S_DONE:
                begin
                    if (req.take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.start)
        begin
            xy_reg.hi <= blk_hi;
            xy_reg.lo <= blk_lo;
            rk_reg    <= keys[0];
            lane0_reg <= keys[1];
            lane1_reg <= keys[2];
            lane2_reg <= keys[3];
        end
        else if (state_reg == S_ROUND)
        begin
            xy_reg    <= xy_next;
            rk_reg    <= rk_next;
            lane0_reg <= lane1_reg;
            lane1_reg <= lane2_reg;
            lane2_reg <= lane_next;
        end
    end

    assign stat.idle     = (state_reg == S_IDLE);
    assign stat.ks_valid = (state_reg == S_DONE);
    assign ks_hi         = xy_reg.hi;
    assign ks_lo         = xy_reg.lo;

endmodule

`default_nettype wire

// File: tb/speck_ctr_checker.sv
`timescale 1ns / 1ps
// Checker for the Speck128/256 CTR cipher: tracks key, nonce and counter, predicts and compares.

module speck_ctr_checker #(
    parameter int ROUNDS = 34
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [speck_ctr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [63:0]                         data_low,
    input  logic [63:0]                         data_high,
    input  logic                                message_start,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [63:0]                         result_low,
    input  logic [63:0]                         result_high,
    output int unsigned                         expected_count,
    output int unsigned                         fail_count
);

    import speck_ctr_pkg::*;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } cipher_block_t;

    logic [63:0]   key_word [4];
    logic [63:0]   nonce_lo;
    logic [63:0]   nonce_hi;
    logic [63:0]   round_key [ROUNDS];
    logic [127:0]  counter;
    cipher_block_t result_q [$];
    int unsigned   fails;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned s);
        return (v >> s) | (v << (64 - s));
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
        return (v << s) | (v >> (64 - s));
    endfunction

    // key schedule: three lanes fed in rotation, round index mixed in
    function automatic void expand_round_keys();
        logic [63:0] lane [3];
        lane[0] = key_word[1];
        lane[1] = key_word[2];
        lane[2] = key_word[3];
        round_key[0] = key_word[0];
        for (int i = 0; i < ROUNDS - 1; i++)
        begin
            lane[i % 3] = (round_key[i] + rotr(lane[i % 3], ROT_RIGHT)) ^ 64'(i);
            round_key[i + 1] = rotl(round_key[i], ROT_LEFT) ^ lane[i % 3];
        end
    endfunction

    // {hi, lo} in, {hi, lo} out
    function automatic logic [127:0] keystream_block(input logic [127:0] blk);
        logic [63:0] x;
        logic [63:0] y;
        x = blk[127:64];
        y = blk[63:0];
        for (int r = 0; r < ROUNDS; r++)
        begin
            x = (rotr(x, ROT_RIGHT) + y) ^ round_key[r];
            y = rotl(y, ROT_LEFT) ^ x;
        end
        return {x, y};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        cipher_block_t want;
        logic [127:0]  pad;
        if (!rst_n)
        begin
            foreach (key_word[k])
                key_word[k] = '0;
            foreach (round_key[r])
                round_key[r] = '0;
            nonce_lo = '0;
            nonce_hi = '0;
            counter  = '0;
            result_q.delete();
            fails = 0;
            expected_count <= 0;
            fail_count     <= 0;
        end
        else
        begin
            // results first: a block accepted on this edge cannot be answered yet
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with nothing outstanding: %h_%h", result_high, result_low);
                    fails++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (result_low !== want.lo)
                    begin
                        $error("result_low: expected %h, actual %h", want.lo, result_low);
                        fails++;
                    end
                    if (result_high !== want.hi)
                    begin
                        $error("result_high: expected %h, actual %h", want.hi, result_high);
                        fails++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KEY_WORD_0: key_word[0] = cfg_data;
                    CFG_KEY_WORD_1: key_word[1] = cfg_data;
                    CFG_KEY_WORD_2: key_word[2] = cfg_data;
                    CFG_KEY_WORD_3: key_word[3] = cfg_data;
                    CFG_NONCE_LOW:  nonce_lo    = cfg_data;
                    CFG_NONCE_HIGH: nonce_hi    = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                if (message_start)
                begin
                    expand_round_keys();
                    counter = {nonce_hi, nonce_lo};
                end
                pad = keystream_block(counter);
                result_q.push_back(cipher_block_t'{lo: data_low ^ pad[63:0],
                                                   hi: data_high ^ pad[127:64]});
                counter = counter + 128'd1;
            end

            expected_count <= result_q.size();
            fail_count     <= fails;
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the Speck128/256 CTR cipher testbench: clock, reset, stimulus and verdict.

module testbench;

    import speck_ctr_pkg::*;

    localparam int ROUNDS = 34;
    // margin after the drain for the engine to go quiet before touching registers
    localparam int FLUSH_CYCLES = ROUNDS + 20;
    localparam int ITEMS_PER_PHASE = 667;
    // 2 ns clock; the timeout lies well beyond the slowest correct run
    localparam int TIMEOUT_NS = 5_000_000;

    // indexes beyond the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_LIST [8] = '{
        CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3,
        CFG_NONCE_LOW, CFG_NONCE_HIGH, CFG_UNUSED_6, CFG_UNUSED_7
    };

    localparam logic [63:0] ALL_ONES = '1;
    localparam logic [63:0] CHECKER_A = 64'h5555_5555_5555_5555;
    localparam logic [63:0] CHECKER_B = 64'haaaa_aaaa_aaaa_aaaa;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [63:0]          data_low = '0;
    logic [63:0]          data_high = '0;
    logic                 message_start = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [63:0]          result_low;
    logic [63:0]          result_high;

    int unsigned expected_count;
    int unsigned fail_count;

    // idle percentages for the sending side and the result side
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    always #1 clk = ~clk;

    speck128_256_ctr_cipher #(
        .ROUND_COUNT (ROUNDS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_low      (data_low),
        .data_high     (data_high),
        .message_start (message_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_low    (result_low),
        .result_high   (result_high)
    );

    speck_ctr_checker #(
        .ROUNDS (ROUNDS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_low       (data_low),
        .data_high      (data_high),
        .message_start  (message_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_low     (result_low),
        .result_high    (result_high),
        .expected_count (expected_count),
        .fail_count     (fail_count)
    );

    // Result side backpressure: a fresh coin every cycle, so stalls land on
    // every phase of the engine's block period.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    // One register write. Ready is looked at on the falling edge, where it is
    // settled for the coming rising edge; valid drops for a cycle afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One block transfer. Valid is not lowered at the end: the next call
    // either keeps it high with a new payload or opens an idle gap.
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic start);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_low      <= lo;
        data_high     <= hi;
        message_start <= start;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drain: no block in flight and the engine quiet, so registers may change.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_count != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] n_lo, input logic [63:0] n_hi);
        write_reg(CFG_KEY_WORD_0, k0);
        write_reg(CFG_KEY_WORD_1, k1);
        write_reg(CFG_KEY_WORD_2, k2);
        write_reg(CFG_KEY_WORD_3, k3);
        write_reg(CFG_NONCE_LOW, n_lo);
        write_reg(CFG_NONCE_HIGH, n_hi);
    endtask

    // Mostly full random words, with the all-zero and all-one extremes mixed in.
    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned msg_len;
        logic        fresh;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------

        // All-zero key and nonce; writes to the unused indexes must not land
        // anywhere. Very first block opens a message, so round keys are defined.
        write_all('0, '0, '0, '0, '0, '0);
        write_reg(CFG_UNUSED_6, ALL_ONES);
        write_reg(CFG_UNUSED_7, ALL_ONES);
        send_block('0, '0, 1'b1);
        send_block(ALL_ONES, ALL_ONES, 1'b0);
        send_block(CHECKER_A, CHECKER_B, 1'b0);
        settle();

        // All-ones key and counter: the second block sees the 128-bit wrap to zero.
        write_all(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_block('0, '0, 1'b1);
        send_block(ALL_ONES, '0, 1'b0);
        send_block('0, ALL_ONES, 1'b0);
        settle();

        // Published-style key, low nonce word saturated: carry into the high word.
        write_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                  64'h1716151413121110, 64'h1f1e1d1c1b1a1918, ALL_ONES, 64'd1);
        send_block(64'h202e72656e6f6f70, 64'h65736f6874206e49, 1'b1);
        send_block(CHECKER_B, CHECKER_A, 1'b0);
        settle();

        // New key and nonce mid-message: old schedule and counter keep running
        // until the next message start picks the new values up.
        write_all(rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word());
        send_block(rand_word(), rand_word(), 1'b0);
        send_block(rand_word(), rand_word(), 1'b0);
        send_block(rand_word(), rand_word(), 1'b1);
        send_block(rand_word(), rand_word(), 1'b0);
        // back-to-back message starts
        send_block(rand_word(), rand_word(), 1'b1);
        send_block(rand_word(), rand_word(), 1'b1);
        settle();

        // ---------------- random part ----------------
        // Three idling profiles: slow sender / slow receiver, then swapped,
        // then full rate on both sides.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 18; rx_idle_pct = 49; end
                1:       begin tx_idle_pct = 49; rx_idle_pct = 18; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // occasional reconfiguration of a random subset, while idle
                if ($urandom_range(3) == 0)
                begin
                    settle();
                    foreach (REG_LIST[r])
                        if ($urandom_range(1) == 1)
                            write_reg(REG_LIST[r], rand_word());
                end
                // mostly short messages, now and then a long one; a few
                // continue the previous message across the register change
                msg_len = ($urandom_range(7) == 0) ? $urandom_range(60, 20)
                                                   : $urandom_range(12, 1);
                fresh = ($urandom_range(4) != 0);
                for (int k = 0; k < msg_len; k++)
                begin
                    send_block(rand_word(), rand_word(),
                               (k == 0 && fresh) || ($urandom_range(49) == 0));
                    sent++;
                end
            end
        end

        // ---------------- wind-down ----------------
        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
